// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: sv/tscd_pkg.sv
// ----------------------------------------------------------------------------
// tscd_pkg
// Types, codes and the CRC-8 byte update shared by the scratchpad decoder.
// ----------------------------------------------------------------------------
package tscd_pkg;

  localparam logic [7:0] FamDs18s20  = 8'h10;
  localparam logic [7:0] FamDs1822   = 8'h22;
  localparam logic [7:0] FamDs18b20  = 8'h28;
  localparam logic [7:0] FamMax31850 = 8'h3B;

  localparam logic [7:0] CrcPoly     = 8'h8C;
  localparam logic [3:0] LastPos     = 4'd8;

  localparam logic signed [19:0] SatMax = 20'sd32767;
  localparam logic signed [19:0] SatMin = -20'sd32768;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CRC_ERR    = 2'd1,
    ST_BAD_FAMILY = 2'd2
  } status_e;

  typedef struct packed {
    logic        fire;
    logic        crc_ok;
    logic [7:0]  family;
    logic [15:0] word;
    logic [7:0]  count_remain;
  } scratch_t;

  // Maxim CRC-8, reflected, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// File: sv/tscd_accum.sv
// ----------------------------------------------------------------------------
// tscd_accum
// Byte position, running CRC and captured scratchpad bytes.
// ----------------------------------------------------------------------------
module tscd_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         family_code_i,
  input  logic               first_byte_i,
  output tscd_pkg::scratch_t scratch_o
);
  import tscd_pkg::*;

  logic [3:0] pos_q, pos_d, pos_eff;
  logic [7:0] crc_q, crc_d, crc_eff;
  logic [7:0] lo_q, lo_d, hi_q, hi_d, cr_q, cr_d;
  logic [7:0] fam_q, fam_d, fam_eff;
  logic       restart;

  always_comb begin
    restart = first_byte_i || (pos_q == 4'd0);
    pos_eff = restart ? 4'd0 : pos_q;
    crc_eff = restart ? 8'd0 : crc_q;
    fam_eff = restart ? family_code_i : fam_q;

    lo_d  = lo_q;
    hi_d  = hi_q;
    cr_d  = cr_q;
    fam_d = fam_eff;

    if (pos_eff < LastPos) begin
      crc_d = crc8_byte(crc_eff, data_byte_i);
      pos_d = pos_eff + 4'd1;
      case (pos_eff)
        4'd0:    lo_d = data_byte_i;
        4'd1:    hi_d = data_byte_i;
        4'd6:    cr_d = data_byte_i;
        default: ;
      endcase
    end else begin
      crc_d = 8'd0;
      pos_d = 4'd0;
    end

    scratch_o.fire         = (pos_eff >= LastPos);
    scratch_o.crc_ok       = (crc_eff == data_byte_i);
    scratch_o.family       = fam_eff;
    scratch_o.word         = {hi_q, lo_q};
    scratch_o.count_remain = cr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
      cr_q  <= '0;
      fam_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      cr_q  <= cr_d;
      fam_q <= fam_d;
    end
  end

endmodule

// File: sv/tscd_decode.sv
// ----------------------------------------------------------------------------
// tscd_decode
// Family-dependent conversion of the temperature word to 1/16 degree C.
// ----------------------------------------------------------------------------
module tscd_decode (
  input  tscd_pkg::scratch_t  scratch_i,
  output logic signed [15:0]  temp_o,
  output tscd_pkg::status_e   status_o
);
  import tscd_pkg::*;

  logic [15:0]        w;
  logic [3:0]         frac;
  logic signed [19:0] coarse, fine;
  logic signed [15:0] s20_sat;

  always_comb begin
    w      = scratch_i.word;
    frac   = 4'(8'h10 - scratch_i.count_remain);
    coarse = {w[15], w[15:1], 4'b0000};
    fine   = coarse + signed'({16'd0, frac}) - 20'sd4;
    if (fine > SatMax) begin
      s20_sat = 16'sh7FFF;
    end else if (fine < SatMin) begin
      s20_sat = 16'sh8000;
    end else begin
      s20_sat = fine[15:0];
    end

    temp_o   = '0;
    status_o = ST_OK;
    if (!scratch_i.crc_ok) begin
      status_o = ST_CRC_ERR;
    end else begin
      unique case (scratch_i.family)
        FamDs18s20:             temp_o = s20_sat;
        FamDs1822, FamDs18b20:  temp_o = signed'(w);
        FamMax31850:            temp_o = signed'({w[15:2], 2'b00});
        default:                status_o = ST_BAD_FAMILY;
      endcase
    end
  end

endmodule

// File: sv/temp_scratchpad_crc_decoder.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decoder
// Scratchpad CRC check and temperature decode for one-wire sensors.
// ----------------------------------------------------------------------------
// Feed the nine scratchpad bytes one request each, tuser high on byte 0 (a
// byte arriving after a completed read also starts a new one). The ninth byte
// is compared with the Maxim CRC-8 of bytes 0..7 and yields one result:
// temperature in signed 1/16 C, status and a valid flag; other bytes yield
// none. One byte per cycle is sustained while the result side does not stall;
// the ninth byte is registered at the input, its result at the output.
module temp_scratchpad_crc_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] data_byte, [15:8] family_code
  input  logic [0:0]  s_axis_tuser_i,  // [0] first_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] temp_sixteenths
  output logic [2:0]  m_axis_tuser_o   // [1:0] status, [2] reading_valid
);
  import tscd_pkg::*;

  logic               in_valid_q;
  logic [15:0]        in_data_q;
  logic               in_first_q;
  logic               advance;
  logic               load_out;
  scratch_t           scratch;
  logic signed [15:0] temp;
  status_e            status;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_temp_q;
  status_e            out_status_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign load_out        = advance && scratch.fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i[0];
    end
  end

  tscd_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_byte_i   (in_data_q[7:0]),
    .family_code_i (in_data_q[15:8]),
    .first_byte_i  (in_first_q),
    .scratch_o     (scratch)
  );

  tscd_decode u_decode (
    .scratch_i (scratch),
    .temp_o    (temp),
    .status_o  (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_temp_q   <= temp;
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_temp_q;
  assign m_axis_tuser_o  = {out_status_q == ST_OK, out_status_q};

endmodule

// File: sv/tscd_checker.sv
// ----------------------------------------------------------------------------
// tscd_checker
// Port-level checks on the scratchpad decoder result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tscd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import tscd_pkg::*;

  logic req_in;
  logic st_ok;

  assign req_in = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != 16'd0 || s_axis_tuser_i[0]);
  assign st_ok  = (m_axis_tuser_o[1:0] == ST_OK);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
  `ASSERT_PROP(a_valid_flag, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tuser_o[2] == st_ok))
  `ASSERT_NEVER(a_bad_status, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o[1:0] == 2'd3))
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni, (m_axis_tvalid_o && !st_ok) |-> (m_axis_tdata_o == 16'd0))
  `ASSERT_PROP(a_no_start_result, clk_i, rst_ni, (req_in && s_axis_tuser_i[0]) |=> ##1 (!m_axis_tvalid_o || $past(m_axis_tvalid_o && !m_axis_tready_i) || $past(m_axis_tvalid_o, 1)))

endmodule

bind temp_scratchpad_crc_decoder tscd_checker u_tscd_checker (.*);

// File: verif/tscd_reading_checker.sv
// ----------------------------------------------------------------------------
// tscd_reading_checker
// Watches both stream channels of the scratchpad decoder. It tracks the
// scratchpad position, the running CRC-8 and the kept bytes of every accepted
// request, works out each decoded reading, and compares the accepted results
// in order, field by field.
// ----------------------------------------------------------------------------
module tscd_reading_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_byte, [15:8] family_code
  input  logic [0:0]  s_axis_tuser_i,   // [0] first_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [15:0] temp_sixteenths
  input  logic [2:0]  m_axis_tuser_i,   // [1:0] status, [2] reading_valid
  output int          errors_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import tscd_pkg::*;

  localparam logic [7:0] ReflPoly = 8'h8C;

  typedef struct {
    logic [15:0] temp;
    status_e     status;
    logic        valid;
  } reading_t;

  reading_t   readings_due[$];
  int         err_cnt;

  logic [3:0] pad_pos;
  logic [7:0] crc_run;
  logic [7:0] lsb_q;
  logic [7:0] msb_q;
  logic [7:0] remain_q;
  logic [7:0] family_q;

  assign errors_o = err_cnt;

  function automatic logic [7:0] crc8_step(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = {1'b0, c[7:1]} ^ (fb ? ReflPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic reading_t decode_reading(input logic [7:0] crc_byte);
    reading_t   r;
    logic [15:0] word;
    logic [7:0]  diff;
    int          t;
    word     = {msb_q, lsb_q};
    r.temp   = '0;
    r.status = ST_OK;
    if (crc_run != crc_byte) begin
      r.status = ST_CRC_ERR;
    end else begin
      case (family_q)
        FamDs18s20: begin
          diff = 8'h10 - remain_q;
          t = int'($signed(word & 16'hFFFE)) * 8 + int'(diff[3:0]) - 4;
          if (t > int'(SatMax)) t = int'(SatMax);
          if (t < int'(SatMin)) t = int'(SatMin);
          r.temp = t[15:0];
        end
        FamDs1822, FamDs18b20: r.temp = word;
        FamMax31850:           r.temp = word & 16'hFFFC;
        default:               r.status = ST_BAD_FAMILY;
      endcase
    end
    r.valid = (r.status == ST_OK);
    return r;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    err_cnt++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic queue_reading(input reading_t r);
    readings_due.insert(readings_due.size(), r);
  endtask

  task automatic take_byte(input logic [7:0] b, input logic [7:0] fam, input logic first);
    if (first || pad_pos == 4'd0) begin
      pad_pos  = 4'd0;
      crc_run  = 8'h00;
      family_q = fam;
    end
    if (pad_pos < LastPos) begin
      crc_run = crc8_step(crc_run, b);
      case (pad_pos)
        4'd0:    lsb_q = b;
        4'd1:    msb_q = b;
        4'd6:    remain_q = b;
        default: ;
      endcase
      pad_pos = pad_pos + 4'd1;
    end else begin
      queue_reading(decode_reading(b));
      pad_pos = 4'd0;
      crc_run = 8'h00;
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      report("unexpected reading", m_axis_tdata_i, 16'h0000);
    end else begin
      want = readings_due.pop_front();
      if (m_axis_tdata_i !== want.temp) begin
        report("temp_sixteenths", m_axis_tdata_i, want.temp);
      end
      if (m_axis_tuser_i[1:0] !== want.status) begin
        report("status", 16'(m_axis_tuser_i[1:0]), 16'(want.status));
      end
      if (m_axis_tuser_i[2] !== want.valid) begin
        report("reading_valid", 16'(m_axis_tuser_i[2]), 16'(want.valid));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pad_pos  = '0;
      crc_run  = '0;
      lsb_q    = '0;
      msb_q    = '0;
      remain_q = '0;
      family_q = '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_byte(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tuser_i[0]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_reading();
      end
    end
    pending_o <= readings_due.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives scratchpad reads into the decoder: a few directed reads, then random
// reads of every family with good and bad CRC, broken reads and byte noise,
// with random gaps on the request side and random stalls on the result side.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tscd_pkg::*;

  localparam int ItemTarget  = 1700;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [7:0] data_byte, [15:8] family_code
  logic [0:0]  s_axis_tuser_i = '0;   // [0] first_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // [15:0] temp_sixteenths
  logic [2:0]  m_axis_tuser_o;        // [1:0] status, [2] reading_valid

  int errors;
  int pending;
  int sent;
  int calm_tx;
  int calm_rx;
  int stall_left;
  int quiet;

  always #5 clk_i = ~clk_i;

  temp_scratchpad_crc_decoder i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  tscd_reading_checker i_chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (calm_rx > 0) begin
        calm_rx <= calm_rx - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) calm_rx <= $urandom_range(30, 100);
        else if (r < 22) stall_left <= $urandom_range(1, 3);
        else if (r < 25) stall_left <= $urandom_range(15, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_tx > 0) begin
      calm_tx--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_tx = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_family();
    case ($urandom_range(0, 9))
      0, 1:    return FamDs18s20;
      2:       return FamDs1822;
      3, 4:    return FamDs18b20;
      5, 6:    return FamMax31850;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_msb();
    logic [7:0] corner [8] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F, 8'h80, 8'h07, 8'hFC};
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    return corner[$urandom_range(0, 7)];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [7:0] fam, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {fam, b};
    s_axis_tuser_i  <= first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_read(input logic [7:0] fam, input logic mark, input logic [7:0] lo,
                           input logic [7:0] hi, input logic [7:0] cr, input logic bad_crc);
    logic [7:0] pad [9];
    logic [7:0] crc;
    pad[0] = lo;
    pad[1] = hi;
    for (int k = 2; k < 8; k++) pad[k] = 8'($urandom);
    pad[6] = cr;
    crc = 8'h00;
    for (int k = 0; k < 8; k++) crc = crc8_byte(crc, pad[k]);
    pad[8] = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
    send_byte(pad[0], fam, mark);
    for (int k = 1; k < 9; k++) send_byte(pad[k], 8'($urandom), 1'b0);
  endtask

  task automatic drain_readings();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int         sel;
    int         n;
    logic       aligned;
    logic [7:0] lo;
    logic [7:0] cr;
    sent    = 0;
    calm_tx = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturates high
    send_read(FamDs18s20, 1'b1, 8'hFF, 8'h7F, 8'h00, 1'b0);
    // aborted read, restarted by a start mark
    send_byte(8'h00, FamDs1822, 1'b1);
    send_byte(8'hFF, 8'h00, 1'b0);
    send_read(FamMax31850, 1'b1, 8'h01, 8'h80, 8'hFF, 1'b0);
    // unsupported family, no start mark
    send_read(8'hFF, 1'b0, 8'h00, 8'h00, 8'h10, 1'b0);
    drain_readings();

    aligned = 1'b1;
    while (sent < ItemTarget) begin
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        lo = ($urandom_range(0, 3) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        cr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 16)) : 8'($urandom);
        send_read(pick_family(), !aligned || ($urandom_range(0, 3) != 0), lo, pick_msb(),
                  cr, $urandom_range(0, 99) < 12);
        aligned = 1'b1;
      end else if (sel < 92) begin
        n = $urandom_range(1, 8);
        send_byte(8'($urandom), pick_family(), 1'b1);
        for (int k = 1; k < n; k++) send_byte(8'($urandom), 8'($urandom), 1'b0);
        aligned = 1'b0;
      end else begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) send_byte(8'($urandom), 8'($urandom), 1'($urandom));
        aligned = 1'b0;
      end
      if ($urandom_range(0, 99) < 3) drain_readings();
    end

    drain_readings();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
